// ----- design/vec3n_pkg.sv -----
// ----------------------------------------------------------------------------
// vec3n_pkg
// Shared widths and defaults for the 3D vector normalizer.
// ----------------------------------------------------------------------------
package vec3n_pkg;
	localparam int FIELD_W        = 32;
	localparam int OUT_W          = 18;
	localparam int QMAG_W         = OUT_W - 1;
	localparam int SUM_W          = 64;
	localparam int ROOT_W         = SUM_W / 2;
	localparam int DEF_FRAC_BITS  = 16;
	localparam int DEF_COMP_WIDTH = 32;
endpackage

// ----- design/vec3n_in_if.sv -----
// ----------------------------------------------------------------------------
// vec3n_in_if
// Input channel: one vector of three signed components per transaction.
// ----------------------------------------------------------------------------
interface vec3n_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [vec3n_pkg::FIELD_W-1:0] comp_x;
	logic signed [vec3n_pkg::FIELD_W-1:0] comp_y;
	logic signed [vec3n_pkg::FIELD_W-1:0] comp_z;
	modport source (output valid, comp_x, comp_y, comp_z, input ready);
	modport sink (input valid, comp_x, comp_y, comp_z, output ready);
endinterface

// ----- design/vec3n_out_if.sv -----
// ----------------------------------------------------------------------------
// vec3n_out_if
// Output channel: one normalized vector and a zero flag per transaction.
// ----------------------------------------------------------------------------
interface vec3n_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [vec3n_pkg::OUT_W-1:0] unit_x;
	logic signed [vec3n_pkg::OUT_W-1:0] unit_y;
	logic signed [vec3n_pkg::OUT_W-1:0] unit_z;
	logic                               zero_length;
	modport source (output valid, unit_x, unit_y, unit_z, zero_length, input ready);
	modport sink (input valid, unit_x, unit_y, unit_z, zero_length, output ready);
endinterface

// ----- design/vec3_normalize.sv -----
// ----------------------------------------------------------------------------
// vec3_normalize
// Scales a signed fixed-point 3D vector to unit length.
// ----------------------------------------------------------------------------
// The block accepts one vector per clock while the output is not stalled and
// returns one result per vector, in order. The pipeline runs through the
// magnitude, square and sum registers, the bit-per-stage square root, the
// three parallel dividers and one output register.
// The whole pipeline holds while a result waits at the output.
module vec3_normalize #(
	parameter int FRAC_BITS  = vec3n_pkg::DEF_FRAC_BITS,
	parameter int COMP_WIDTH = vec3n_pkg::DEF_COMP_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	vec3n_in_if.sink    in_ch,
	vec3n_out_if.source out_ch
);
	import vec3n_pkg::*;

	localparam int SIDE_W = 3 * COMP_WIDTH + 3;

	logic en;
	logic out_vld_q;

	logic                  vld_s1, vld_s2, vld_s3;
	logic [COMP_WIDTH-1:0] mag_s1 [0:2];
	logic [COMP_WIDTH-1:0] mag_s2 [0:2];
	logic [COMP_WIDTH-1:0] mag_s3 [0:2];
	logic [2:0]            neg_s1, neg_s2, neg_s3;
	logic [2*COMP_WIDTH-1:0] sq_s2 [0:2];
	logic [SUM_W-1:0]      sum_s3;
	logic [COMP_WIDTH-1:0] raw [0:2];

	logic              rt_vld;
	logic [ROOT_W-1:0] rt_len;
	logic [SIDE_W-1:0] rt_side;

	logic              dv_vld [0:2];
	logic [QMAG_W-1:0] dv_q [0:2];
	logic [1:0]        dv_side [0:2];
	logic signed [OUT_W-1:0] unit_q [0:2];
	logic              zero_q;

	assign en          = out_ch.ready || !out_vld_q;
	assign in_ch.ready = en;

	assign raw[0] = in_ch.comp_x[COMP_WIDTH-1:0];
	assign raw[1] = in_ch.comp_y[COMP_WIDTH-1:0];
	assign raw[2] = in_ch.comp_z[COMP_WIDTH-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_ch.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= raw[i][COMP_WIDTH-1];
				mag_s1[i] <= raw[i][COMP_WIDTH-1] ? (~raw[i] + 1'b1) : raw[i];
				sq_s2[i]  <= mag_s1[i] * mag_s1[i];
				mag_s2[i] <= mag_s1[i];
				mag_s3[i] <= mag_s2[i];
			end
			neg_s2 <= neg_s1;
			neg_s3 <= neg_s2;
			sum_s3 <= SUM_W'(sq_s2[0]) + SUM_W'(sq_s2[1]) + SUM_W'(sq_s2[2]);
		end
	end

	vec3n_sqrt #(
		.SIDE_W (SIDE_W)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_in   (vld_s3),
		.radicand (sum_s3),
		.side_in  ({neg_s3, mag_s3[2], mag_s3[1], mag_s3[0]}),
		.vld_out  (rt_vld),
		.root     (rt_len),
		.side_out (rt_side)
	);

	for (genvar c = 0; c < 3; c++) begin : g_div
		vec3n_div #(
			.COMP_WIDTH (COMP_WIDTH),
			.FRAC_BITS  (FRAC_BITS)
		) u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.vld_in   (rt_vld),
			.mag      (rt_side[c*COMP_WIDTH +: COMP_WIDTH]),
			.len      (rt_len),
			.side_in  ({rt_len == '0, rt_side[3*COMP_WIDTH + c]}),
			.vld_out  (dv_vld[c]),
			.quot     (dv_q[c]),
			.side_out (dv_side[c])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= dv_vld[0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_q <= dv_side[0][1];
			for (int i = 0; i < 3; i++) begin
				if (dv_side[i][1]) begin
					unit_q[i] <= '0;
				end else if (dv_side[i][0]) begin
					unit_q[i] <= -$signed({1'b0, dv_q[i]});
				end else begin
					unit_q[i] <= $signed({1'b0, dv_q[i]});
				end
			end
		end
	end

	assign out_ch.valid       = out_vld_q;
	assign out_ch.unit_x      = unit_q[0];
	assign out_ch.unit_y      = unit_q[1];
	assign out_ch.unit_z      = unit_q[2];
	assign out_ch.zero_length = zero_q;
endmodule

// ----- design/vec3n_sqrt.sv -----
// ----------------------------------------------------------------------------
// vec3n_sqrt
// Pipelined floor square root, one result bit per stage, with sideband.
// ----------------------------------------------------------------------------
module vec3n_sqrt #(
	parameter int SIDE_W = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          vld_in,
	input  logic [vec3n_pkg::SUM_W-1:0]   radicand,
	input  logic [SIDE_W-1:0]             side_in,
	output logic                          vld_out,
	output logic [vec3n_pkg::ROOT_W-1:0]  root,
	output logic [SIDE_W-1:0]             side_out
);
	import vec3n_pkg::*;

	logic             vld_s  [0:ROOT_W];
	logic [SUM_W-1:0] rem_s  [0:ROOT_W];
	logic [SUM_W-1:0] res_s  [0:ROOT_W];
	logic [SIDE_W-1:0] side_s [0:ROOT_W];

	assign vld_s[0]  = vld_in;
	assign rem_s[0]  = radicand;
	assign res_s[0]  = '0;
	assign side_s[0] = side_in;

	for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
		localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (SUM_W - 2 - 2 * i);
		logic [SUM_W-1:0] trial;
		assign trial = res_s[i] + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[i+1] <= side_s[i];
				if (rem_s[i] >= trial) begin
					rem_s[i+1] <= rem_s[i] - trial;
					res_s[i+1] <= (res_s[i] >> 1) + BIT;
				end else begin
					rem_s[i+1] <= rem_s[i];
					res_s[i+1] <= res_s[i] >> 1;
				end
			end
		end
	end

	assign vld_out  = vld_s[ROOT_W];
	assign root     = res_s[ROOT_W][ROOT_W-1:0];
	assign side_out = side_s[ROOT_W];
endmodule

// ----- design/vec3n_div.sv -----
// ----------------------------------------------------------------------------
// vec3n_div
// Pipelined restoring divider for one component, with overflow detection.
// ----------------------------------------------------------------------------
module vec3n_div #(
	parameter int COMP_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          vld_in,
	input  logic [COMP_WIDTH-1:0]         mag,
	input  logic [vec3n_pkg::ROOT_W-1:0]  len,
	input  logic [1:0]                    side_in,
	output logic                          vld_out,
	output logic [vec3n_pkg::QMAG_W-1:0]  quot,
	output logic [1:0]                    side_out
);
	import vec3n_pkg::*;

	localparam logic [QMAG_W-1:0] QMAX = '1;

	logic              vld_s  [0:QMAG_W];
	logic [SUM_W-1:0]  rem_s  [0:QMAG_W];
	logic [QMAG_W-1:0] q_s    [0:QMAG_W];
	logic              ovf_s  [0:QMAG_W];
	logic [ROOT_W-1:0] len_s  [0:QMAG_W];
	logic [1:0]        side_s [0:QMAG_W];
	logic [SUM_W-1:0]  dividend;

	assign dividend = SUM_W'(mag) << FRAC_BITS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= dividend;
			q_s[0]    <= '0;
			ovf_s[0]  <= dividend >= (SUM_W'(len) << QMAG_W);
			len_s[0]  <= len;
			side_s[0] <= side_in;
		end
	end

	for (genvar j = 0; j < QMAG_W; j++) begin : g_stage
		localparam int K = QMAG_W - 1 - j;
		logic [SUM_W-1:0] dsh;
		assign dsh = SUM_W'(len_s[j]) << K;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (en) begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ovf_s[j+1]  <= ovf_s[j];
				len_s[j+1]  <= len_s[j];
				side_s[j+1] <= side_s[j];
				if (rem_s[j] >= dsh) begin
					rem_s[j+1] <= rem_s[j] - dsh;
					q_s[j+1]   <= q_s[j] | (QMAG_W'(1) << K);
				end else begin
					rem_s[j+1] <= rem_s[j];
					q_s[j+1]   <= q_s[j];
				end
			end
		end
	end

	assign vld_out  = vld_s[QMAG_W];
	assign quot     = ovf_s[QMAG_W] ? QMAX : q_s[QMAG_W];
	assign side_out = side_s[QMAG_W];
endmodule
